FILE: src/mbrot_pkg.sv
package mbrot_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int COORD_W    = 32;
    localparam int ITER_W     = 16;
    localparam int PIX_W      = 17;
    localparam int Z_W        = FRAC_BITS + 6;
    localparam int MAG_W      = FRAC_BITS + 3;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int RING_DEPTH = 4;
    localparam int SEQ_W      = $clog2(RING_DEPTH) + 1;
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic signed [Z_W-1:0] ESC_LIM = Z_W'(64'sd4 <<< FRAC_BITS);
    localparam logic [PROD_W:0]       SUM_LIM = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 4);
    localparam logic signed [PIX_W-1:0] PIX_INSIDE = '1;

    localparam logic signed [COORD_W-1:0] X_MIN_RST  = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] Y_MIN_RST  = -32'sd402653184;
    localparam logic signed [COORD_W-1:0] STEP_X_RST = 32'sd4026532;
    localparam logic signed [COORD_W-1:0] STEP_Y_RST = 32'sd4026532;
    localparam logic [ITER_W-1:0]         MAX_IT_RST = 16'd100;

    typedef enum logic [2:0] {
        REG_X_MIN    = 3'd0,
        REG_Y_MIN    = 3'd1,
        REG_STEP_X   = 3'd2,
        REG_STEP_Y   = 3'd3,
        REG_ITER_CAP = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] step_x;
        logic signed [COORD_W-1:0] step_y;
        logic [ITER_W-1:0]         iter_cap;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } coord_t;

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic [SEQ_W-1:0]        seq;
        logic [ITER_W-1:0]       iter;
        logic signed [PIX_W-1:0] result;
        coord_t                  c;
    } tok_t;

endpackage

FILE: src/mbrot_apb.sv
module mbrot_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbrot_pkg::ADDR_W-1:0] paddr,
    input  logic [mbrot_pkg::APB_W-1:0]  pwdata,
    output logic [mbrot_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output mbrot_pkg::cfg_t             cfg
);
    import mbrot_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_X_MIN:    cfg_next.x_min    = pwdata;
                REG_Y_MIN:    cfg_next.y_min    = pwdata;
                REG_STEP_X:   cfg_next.step_x   = pwdata;
                REG_STEP_Y:   cfg_next.step_y   = pwdata;
                REG_ITER_CAP: cfg_next.iter_cap = pwdata[ITER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_MIN:    prdata = cfg_reg.x_min;
            REG_Y_MIN:    prdata = cfg_reg.y_min;
            REG_STEP_X:   prdata = cfg_reg.step_x;
            REG_STEP_Y:   prdata = cfg_reg.step_y;
            REG_ITER_CAP: prdata = APB_W'(cfg_reg.iter_cap);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min    <= X_MIN_RST;
            cfg_reg.y_min    <= Y_MIN_RST;
            cfg_reg.step_x   <= STEP_X_RST;
            cfg_reg.step_y   <= STEP_Y_RST;
            cfg_reg.iter_cap <= MAX_IT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/mbrot_coord.sv
module mbrot_coord (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mbrot_pkg::cfg_t            cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mbrot_pkg::DIM_W-1:0] in_col,
    input  logic [mbrot_pkg::DIM_W-1:0] in_row,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mbrot_pkg::coord_t          out_c
);
    import mbrot_pkg::*;

    localparam int PRODC_W = DIM_W + 1 + COORD_W;
    localparam int SUMC_W  = PRODC_W + 1;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUMC_W-1:0] v
    );
        logic [SUMC_W-COORD_W:0] upper;
        logic signed [COORD_W-1:0] res;
        upper = v[SUMC_W-1:COORD_W-1];
        if ((&upper) || (~|upper))
            res = v[COORD_W-1:0];
        else if (v[SUMC_W-1])
            res = {1'b1, {(COORD_W-1){1'b0}}};
        else
            res = {1'b0, {(COORD_W-1){1'b1}}};
        return res;
    endfunction

    logic                      a_valid_reg, a_valid_next;
    logic [DIM_W-1:0]          col_reg, row_reg;
    logic                      b_valid_reg, b_valid_next;
    logic signed [PRODC_W-1:0] pre_reg, pim_reg, pre_next, pim_next;
    logic                      c_valid_reg, c_valid_next;
    coord_t                    c_reg, c_next;
    logic signed [PRODC_W-1:0] col_ext, row_ext, stx_ext, sty_ext;
    logic signed [SUMC_W-1:0]  sum_re, sum_im;
    logic                      a_take, b_take, c_take;

    assign c_take   = !c_valid_reg || out_ready;
    assign b_take   = !b_valid_reg || c_take;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;

    assign out_valid = c_valid_reg;
    assign out_c     = c_reg;

    assign col_ext = PRODC_W'($signed({1'b0, col_reg}));
    assign row_ext = PRODC_W'($signed({1'b0, row_reg}));
    assign stx_ext = PRODC_W'(cfg.step_x);
    assign sty_ext = PRODC_W'(cfg.step_y);

    always_comb
    begin
        a_valid_next = a_take ? in_valid : a_valid_reg;
        b_valid_next = b_take ? a_valid_reg : b_valid_reg;
        c_valid_next = c_take ? b_valid_reg : c_valid_reg;
        pre_next     = col_ext * stx_ext;
        pim_next     = row_ext * sty_ext;
        sum_re       = SUMC_W'(pre_reg) + SUMC_W'(cfg.x_min);
        sum_im       = SUMC_W'(pim_reg) + SUMC_W'(cfg.y_min);
        c_next.c_re  = sat_coord(sum_re);
        c_next.c_im  = sat_coord(sum_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (b_take)
        begin
            pre_reg <= pre_next;
            pim_reg <= pim_next;
        end
        if (c_take)
        begin
            c_reg <= c_next;
        end
    end

endmodule

FILE: src/mbrot_ring.sv
module mbrot_ring (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mbrot_pkg::ITER_W-1:0]       iter_cap,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mbrot_pkg::coord_t                 in_c,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mbrot_pkg::PIX_W-1:0] out_pixel
);
    import mbrot_pkg::*;

    tok_t                     tok1_reg, tok1_next;
    logic signed [Z_W-1:0]    re1_reg, im1_reg, re1_next, im1_next;
    tok_t                     tok2_reg, tok2_next;
    logic [MAG_W-1:0]         mre2_reg, mim2_reg, mre2_next, mim2_next;
    logic                     neg2_reg, neg2_next;
    tok_t                     tok3_reg, tok3_next;
    logic [PROD_W-1:0]        prr3_reg, pii3_reg, pri3_reg;
    logic [PROD_W-1:0]        prr3_next, pii3_next, pri3_next;
    logic                     neg3_reg, neg3_next;
    tok_t                     tok4_reg, tok4_next;
    logic signed [DIFF_W-1:0] diff4_reg, cross4_reg, diff4_next, cross4_next;

    logic [SEQ_W-1:0]         in_seq_reg, in_seq_next;
    logic [SEQ_W-1:0]         out_seq_reg, out_seq_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [PIX_W-1:0]  out_pixel_reg;

    logic                     out_free, retire, slot_free, insert;
    logic signed [Z_W-1:0]    re_abs, im_abs;
    logic                     out_range;
    logic [PROD_W:0]          sum3;
    logic [DIFF_W-1:0]        cross_mag;
    tok_t                     upd_tok;
    logic signed [Z_W-1:0]    re_upd, im_upd;
    logic [RING_DEPTH-1:0]    valid_vec;

    assign out_free  = !out_valid_reg || out_ready;
    assign retire    = tok4_reg.valid && tok4_reg.done
                       && (tok4_reg.seq == out_seq_reg) && out_free;
    assign slot_free = !tok4_reg.valid || retire;
    assign insert    = slot_free && in_valid;
    assign in_ready  = slot_free;

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    // limit and range check, split into magnitudes
    always_comb
    begin
        tok2_next = tok1_reg;
        re_abs    = re1_reg[Z_W-1] ? -re1_reg : re1_reg;
        im_abs    = im1_reg[Z_W-1] ? -im1_reg : im1_reg;
        out_range = (re1_reg > ESC_LIM) || (re1_reg < -ESC_LIM)
                    || (im1_reg > ESC_LIM) || (im1_reg < -ESC_LIM);
        if (!tok1_reg.done)
        begin
            if (tok1_reg.iter >= iter_cap)
            begin
                tok2_next.done   = 1'b1;
                tok2_next.result = PIX_INSIDE;
            end
            else if (out_range)
            begin
                tok2_next.done   = 1'b1;
                tok2_next.result = PIX_W'(tok1_reg.iter);
            end
        end
        mre2_next = re_abs[MAG_W-1:0];
        mim2_next = im_abs[MAG_W-1:0];
        neg2_next = re1_reg[Z_W-1] ^ im1_reg[Z_W-1];
    end

    // square and cross products
    always_comb
    begin
        tok3_next = tok2_reg;
        prr3_next = mre2_reg * mre2_reg;
        pii3_next = mim2_reg * mim2_reg;
        pri3_next = mre2_reg * mim2_reg;
        neg3_next = neg2_reg;
    end

    // magnitude test, then real and imaginary parts before scaling
    always_comb
    begin
        tok4_next = tok3_reg;
        sum3      = {1'b0, prr3_reg} + {1'b0, pii3_reg};
        if (!tok3_reg.done && (sum3 > SUM_LIM))
        begin
            tok4_next.done   = 1'b1;
            tok4_next.result = PIX_W'(tok3_reg.iter);
        end
        diff4_next  = $signed({1'b0, prr3_reg}) - $signed({1'b0, pii3_reg});
        cross_mag   = {pri3_reg, 1'b0};
        cross4_next = neg3_reg ? -$signed(cross_mag) : $signed(cross_mag);
    end

    // scale, add c, advance the count; retire or insert at the ring entry
    always_comb
    begin
        upd_tok = tok4_reg;
        re_upd  = Z_W'(diff4_reg >>> FRAC_BITS) + Z_W'(tok4_reg.c.c_re);
        im_upd  = Z_W'(cross4_reg >>> FRAC_BITS) + Z_W'(tok4_reg.c.c_im);
        if (!tok4_reg.done)
            upd_tok.iter = tok4_reg.iter + ITER_W'(1);

        priority if (insert)
        begin
            tok1_next        = '0;
            tok1_next.valid  = 1'b1;
            tok1_next.seq    = in_seq_reg;
            tok1_next.c      = in_c;
            re1_next         = '0;
            im1_next         = '0;
        end
        else if (retire)
        begin
            tok1_next = '0;
            re1_next  = re_upd;
            im1_next  = im_upd;
        end
        else
        begin
            tok1_next = upd_tok;
            re1_next  = re_upd;
            im1_next  = im_upd;
        end

        in_seq_next    = insert ? in_seq_reg + SEQ_W'(1) : in_seq_reg;
        out_seq_next   = retire ? out_seq_reg + SEQ_W'(1) : out_seq_reg;
        out_valid_next = retire || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg      <= '0;
            tok2_reg      <= '0;
            tok3_reg      <= '0;
            tok4_reg      <= '0;
            in_seq_reg    <= '0;
            out_seq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tok1_reg      <= tok1_next;
            tok2_reg      <= tok2_next;
            tok3_reg      <= tok3_next;
            tok4_reg      <= tok4_next;
            in_seq_reg    <= in_seq_next;
            out_seq_reg   <= out_seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re1_reg    <= re1_next;
        im1_reg    <= im1_next;
        mre2_reg   <= mre2_next;
        mim2_reg   <= mim2_next;
        neg2_reg   <= neg2_next;
        prr3_reg   <= prr3_next;
        pii3_reg   <= pii3_next;
        pri3_reg   <= pri3_next;
        neg3_reg   <= neg3_next;
        diff4_reg  <= diff4_next;
        cross4_reg <= cross4_next;
        if (retire)
            out_pixel_reg <= tok4_reg.result;
    end

    assign valid_vec = {tok1_reg.valid, tok2_reg.valid, tok3_reg.valid, tok4_reg.valid};

    a_inflight_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(SEQ_W'(in_seq_reg - out_seq_reg)))
        else $error("ring token count does not match sequence counters");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (tok4_reg.valid && tok4_reg.done && !retire)
        |=> (tok1_reg.valid && tok1_reg.done && tok1_reg.result == $past(tok4_reg.result)))
        else $error("finished pixel lost or altered while waiting to retire");

    a_lap_time: assert property (@(posedge clk) disable iff (!rst_n)
        insert |=> ##(RING_DEPTH-1)
        (tok4_reg.valid && tok4_reg.seq == $past(in_seq_reg, RING_DEPTH)))
        else $error("inserted pixel did not reach the ring end after one lap");

endmodule

FILE: src/mandelbrot_escape_time_pixel.sv
// c is formed in the input, product and sum registers; each z loop iteration is a lap
//   of the ring, and a final lap ends by loading the output register.
// The four-stage iteration ring holds up to four pixels, so a new pixel can enter
//   before earlier ones finish; pixels leave the ring in the order they entered.
// Reset: rst_n clears all valid bits, sequence counters and the output valid flag, and
//   restores the plane registers to their default values.
module mandelbrot_escape_time_pixel (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mbrot_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // col, row
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mbrot_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // pixel_value, zero fill
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbrot_pkg::ADDR_W-1:0]     paddr,
    input  logic [mbrot_pkg::APB_W-1:0]      pwdata,
    output logic [mbrot_pkg::APB_W-1:0]      prdata,
    output logic                             pready
);
    import mbrot_pkg::*;

    cfg_t                    cfg;
    coord_t                  coord;
    logic                    coord_valid;
    logic                    coord_ready;
    logic signed [PIX_W-1:0] pixel_value;

    mbrot_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbrot_coord u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_col    (s_axis_tdata[DIM_W-1:0]),
        .in_row    (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .out_valid (coord_valid),
        .out_ready (coord_ready),
        .out_c     (coord)
    );

    mbrot_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .iter_cap  (cfg.iter_cap),
        .in_valid  (coord_valid),
        .in_ready  (coord_ready),
        .in_c      (coord),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (pixel_value)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-PIX_W){1'b0}}, pixel_value};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import mbrot_pkg::*;

    typedef struct {
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        bit               drain;
    } pixel_req_t;

    localparam logic [2:0] NO_REG_FIRST = 3'(REG_ITER_CAP) + 3'd1;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [ADDR_W-1:0]      paddr         = '0;
    logic [APB_W-1:0]       pwdata        = '0;
    logic [APB_W-1:0]       prdata;
    logic                   pready;

    logic signed [COORD_W-1:0] plane_x_min  = X_MIN_RST;
    logic signed [COORD_W-1:0] plane_y_min  = Y_MIN_RST;
    logic signed [COORD_W-1:0] plane_step_x = STEP_X_RST;
    logic signed [COORD_W-1:0] plane_step_y = STEP_Y_RST;
    logic [ITER_W-1:0]         iter_limit   = MAX_IT_RST;

    pixel_req_t              pixel_q[$];
    logic signed [PIX_W-1:0] escape_counts_q[$];
    pixel_req_t              next_px;
    logic signed [PIX_W-1:0] want_pix;

    int        loaded_cnt = 0;
    int        issued_cnt = 0;
    int        done_cnt   = 0;
    int        err_cnt    = 0;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        gap_max    = 0;
    logic [15:0] stall_pat = 16'hB6DB;
    logic [3:0]  ready_rot = '0;

    mandelbrot_escape_time_pixel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // col, row
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // pixel_value, zero fill
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 50)
            $display("[%0t] MISMATCH %s", $time, msg);
        err_cnt++;
    endtask

    function automatic longint sat_coord(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [PIX_W-1:0] escape_count(input logic [DIM_W-1:0] col,
                                                              input logic [DIM_W-1:0] row);
        longint      lim;
        longint      c_re;
        longint      c_im;
        longint      re;
        longint      im;
        longint      re_next;
        int unsigned n;
        lim  = longint'(4) <<< FRAC_BITS;
        c_re = sat_coord(longint'(plane_x_min) + longint'(col) * longint'(plane_step_x));
        c_im = sat_coord(longint'(plane_y_min) + longint'(row) * longint'(plane_step_y));
        re   = 0;
        im   = 0;
        n    = 0;
        while (n < iter_limit)
        begin
            if (re > lim || re < -lim || im > lim || im < -lim)
                break;
            if (re * re + im * im > (longint'(16) <<< (2 * FRAC_BITS)))
                break;
            re_next = ((re * re - im * im) >>> FRAC_BITS) + c_re;
            im      = ((2 * re * im) >>> FRAC_BITS) + c_im;
            re      = re_next;
            n++;
        end
        return (n < iter_limit) ? PIX_W'(n) : PIX_INSIDE;
    endfunction

    // sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                escape_counts_q.push_back(escape_count(s_axis_tdata[DIM_W-1:0],
                                                       s_axis_tdata[2*DIM_W-1:DIM_W]));
                issued_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_q.size() > 0 && !(pixel_q[0].drain && issued_cnt != done_cnt))
                begin
                    next_px = pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({next_px.row, next_px.col});
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 23);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall on a rotating pattern, check each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_rot     <= '0;
        end
        else
        begin
            m_axis_tready <= stall_pat[ready_rot];
            ready_rot     <= ready_rot + 4'd1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                done_cnt <= done_cnt + 1;
                if (escape_counts_q.size() == 0)
                    report_mismatch($sformatf("pixel_value %0d with no pixel pending",
                                              $signed(m_axis_tdata[PIX_W-1:0])));
                else
                begin
                    want_pix = escape_counts_q.pop_front();
                    if (m_axis_tdata[PIX_W-1:0] !== want_pix)
                        report_mismatch($sformatf("pixel_value got %0d want %0d",
                                                  $signed(m_axis_tdata[PIX_W-1:0]), want_pix));
                end
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2 +: 3] < NO_REG_FIRST)
        begin
            case (reg_idx_t'(addr[2 +: 3]))
                REG_X_MIN:    plane_x_min  = data;
                REG_Y_MIN:    plane_y_min  = data;
                REG_STEP_X:   plane_step_x = data;
                REG_STEP_Y:   plane_step_y = data;
                REG_ITER_CAP: iter_limit   = data[ITER_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic apb_read(input reg_idx_t idx, input logic [APB_W-1:0] want,
                            input logic [APB_W-1:0] mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (want & mask))
            report_mismatch($sformatf("register %s read 0x%08h want 0x%08h",
                                      idx.name(), prdata & mask, want & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_plane(input logic [31:0] xm, input logic [31:0] ym,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [ITER_W-1:0] lim);
        apb_write({REG_X_MIN, 2'b00}, xm);
        apb_write({REG_Y_MIN, 2'b00}, ym);
        apb_write({REG_STEP_X, 2'b00}, sx);
        apb_write({REG_STEP_Y, 2'b00}, sy);
        apb_write({REG_ITER_CAP, 2'b00}, APB_W'(lim));
    endtask

    task automatic check_regs();
        apb_read(REG_X_MIN, plane_x_min, '1);
        apb_read(REG_Y_MIN, plane_y_min, '1);
        apb_read(REG_STEP_X, plane_step_x, '1);
        apb_read(REG_STEP_Y, plane_step_y, '1);
        apb_read(REG_ITER_CAP, APB_W'(iter_limit), APB_W'(16'hFFFF));
    endtask

    task automatic queue_pixel(input int col, input int row, input bit drain);
        pixel_req_t px;
        px.col   = DIM_W'(col);
        px.row   = DIM_W'(row);
        px.drain = drain;
        pixel_q.push_back(px);
        loaded_cnt++;
    endtask

    // hold until every queued pixel has come back
    task automatic wait_drain();
        do
            @(posedge clk);
        while (done_cnt != loaded_cnt);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int          ph;
        int          k;
        int          col;
        int          row;
        bit          raw;
        logic [31:0] xm;
        logic [31:0] ym;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [ITER_W-1:0] lim;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        check_regs();

        // default plane: corners, alternating bits, a point next to the origin
        @(negedge clk);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(4095, 4095, 1'b0);
        queue_pixel(4095, 0, 1'b0);
        queue_pixel(0, 4095, 1'b0);
        queue_pixel(12'hAAA, 12'h555, 1'b0);
        queue_pixel(12'h555, 12'hAAA, 1'b1);
        queue_pixel(133, 100, 1'b0);
        queue_pixel(100, 100, 1'b0);

        // saturate c toward the top and bottom of the range
        wait_drain();
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd2);
        check_regs();
        @(negedge clk);
        queue_pixel(4095, 4095, 1'b0);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(1, 1, 1'b0);
        wait_drain();
        set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd3);
        @(negedge clk);
        queue_pixel(4095, 0, 1'b0);
        queue_pixel(0, 4095, 1'b0);
        queue_pixel(2048, 2048, 1'b0);

        // zero iteration limit, then writes to unmapped addresses
        wait_drain();
        set_plane(32'd0, 32'd0, 32'd1 << 20, 32'd1 << 20, 16'd0);
        @(negedge clk);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(7, 3, 1'b0);
        queue_pixel(4095, 4095, 1'b0);
        wait_drain();
        for (k = int'(NO_REG_FIRST); k < 8; k++)
            apb_write(ADDR_W'(k << 2), $urandom());
        check_regs();

        // largest iteration limit
        apb_write({REG_ITER_CAP, 2'b00}, APB_W'(16'hFFFF));
        @(negedge clk);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(4095, 4095, 1'b0);
        queue_pixel(64, 64, 1'b0);

        for (ph = 0; ph < 6; ph++)
        begin
            wait_drain();
            raw = (ph == 4);
            if (raw)
            begin
                xm = $urandom();
                ym = $urandom();
                sx = $urandom();
                sy = $urandom();
            end
            else
            begin
                xm = $urandom_range(0, 805306368) - 671088640;
                ym = $urandom_range(0, 402653184) - 335544320;
                sx = $urandom_range(32'h4_0000, 32'h40_0000);
                sy = $urandom_range(32'h4_0000, 32'h40_0000);
            end
            case (ph)
                0:       lim = 16'd100;
                1:       lim = 16'd200;
                2:       lim = 16'd1;
                3:       lim = ITER_W'($urandom_range(2, 60));
                4:       lim = ITER_W'($urandom_range(1, 150));
                default: lim = ITER_W'($urandom_range(2, 24));
            endcase
            set_plane(xm, ym, sx, sy, lim);
            check_regs();
            @(negedge clk);
            case (ph)
                0:       begin gap_max = 0;  stall_pat = 16'hFFFF; end
                1:       begin gap_max = 4;  stall_pat = 16'($urandom()) | 16'h0001; end
                2:       begin gap_max = 12; stall_pat = 16'h0101; end
                3:       begin gap_max = 2;  stall_pat = 16'hFFFF; end
                4:       begin gap_max = 6;  stall_pat = 16'($urandom()) | 16'h8000; end
                default: begin gap_max = 0;  stall_pat = 16'hF0F0; end
            endcase
            for (k = 0; k < 230; k++)
            begin
                if (raw || $urandom_range(0, 9) == 0)
                begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                else
                begin
                    col = $urandom_range(0, 255);
                    row = $urandom_range(0, 255);
                end
                queue_pixel(col, row, k == 115);
            end
        end

        wait_drain();
        repeat (40) @(posedge clk);
        if (escape_counts_q.size() != 0)
            report_mismatch($sformatf("%0d pixel results never arrived",
                                      escape_counts_q.size()));
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
